// ===== src/pidb_pkg.sv =====
package pidb_pkg;

	// Default storage geometry.
	localparam int PIDB_DEPTH      = 256;
	localparam int PIDB_WORD_WIDTH = 32;

	// Field widths fixed by the interface.
	localparam int CMD_W    = 2;
	localparam int POS_W    = 9;
	localparam int VALUE_W  = 32;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 9;
	localparam int CAP_W    = 9;

	localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

	typedef enum logic [CMD_W-1:0] {
		CMD_INSERT = 2'd0,
		CMD_REMOVE = 2'd1,
		CMD_READ   = 2'd2,
		CMD_WRITE  = 2'd3
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_RANGE = 2'd2
	} status_t;

	// Operation broadcast to every cell of the chain at once.
	typedef struct packed {
		logic ins;   // open a slot at pos, later cells take their lower neighbor
		logic rem;   // close the slot at pos, later cells take their upper neighbor
		logic wr;    // overwrite the cell at pos
	} pidb_op_t;

endpackage

// ===== src/pidb_cell.sv =====
module pidb_cell import pidb_pkg::*; #(
	parameter int IDX_W      = 8,
	parameter int WORD_WIDTH = PIDB_WORD_WIDTH,
	parameter int IDX        = 0
) (
	input  logic                  clk,
	input  pidb_op_t              op,
	input  logic [IDX_W-1:0]      pos,
	input  logic [WORD_WIDTH-1:0] val,
	input  logic [WORD_WIDTH-1:0] lower,
	input  logic [WORD_WIDTH-1:0] upper,
	output logic [WORD_WIDTH-1:0] data,
	output logic [WORD_WIDTH-1:0] rd_word
);

	localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

	logic [WORD_WIDTH-1:0] data_q;
	logic                  hit;
	logic                  above;

	assign hit   = (pos == MY_IDX);
	assign above = (MY_IDX > pos);

	always_ff @(posedge clk) begin
		priority if (op.ins && above) begin
			data_q <= lower;
		end else if ((op.ins || op.wr) && hit) begin
			data_q <= val;
		end else if (op.rem && (above || hit)) begin
			data_q <= upper;
		end else begin
			data_q <= data_q;
		end
	end

	assign data    = data_q;
	// Only the addressed cell puts its word on the read bus.
	assign rd_word = hit ? data_q : '0;

endmodule

// ===== src/pidb_chain.sv =====
module pidb_chain import pidb_pkg::*; #(
	parameter int DEPTH      = PIDB_DEPTH,
	parameter int WORD_WIDTH = PIDB_WORD_WIDTH,
	parameter int IDX_W      = $clog2(DEPTH)
) (
	input  logic                  clk,
	input  pidb_op_t              op,
	input  logic [IDX_W-1:0]      pos,
	input  logic [WORD_WIDTH-1:0] val,
	output logic [WORD_WIDTH-1:0] rd_word
);

	logic [WORD_WIDTH-1:0] data  [DEPTH];
	logic [WORD_WIDTH-1:0] rd_of [DEPTH];

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [WORD_WIDTH-1:0] lower_w;
		logic [WORD_WIDTH-1:0] upper_w;

		// The bottom cell never shifts up and the top cell's upper word is
		// beyond the sequence, so both ends simply feed back their own word.
		if (i == 0) begin : g_bot
			assign lower_w = data[i];
		end else begin : g_mid_lo
			assign lower_w = data[i-1];
		end
		if (i == DEPTH - 1) begin : g_top
			assign upper_w = data[i];
		end else begin : g_mid_hi
			assign upper_w = data[i+1];
		end

		pidb_cell #(
			.IDX_W      (IDX_W),
			.WORD_WIDTH (WORD_WIDTH),
			.IDX        (i)
		) u_cell (
			.clk     (clk),
			.op      (op),
			.pos     (pos),
			.val     (val),
			.lower   (lower_w),
			.upper   (upper_w),
			.data    (data[i]),
			.rd_word (rd_of[i])
		);
	end

	always_comb begin
		rd_word = '0;
		for (int k = 0; k < DEPTH; k++) begin
			rd_word = rd_word | rd_of[k];
		end
	end

endmodule

// ===== src/positional_insert_delete_buffer.sv =====
// Channel | Direction | Handshake          | Payload
// --------+-----------+--------------------+-------------------------------------
// in      | input     | in_valid/in_ready  | command, position, value
// out     | output    | out_valid/out_ready| status, read_data, element_count
// cfg     | input     | cfg_wr_en (no wait)| cfg_wr_data = capacity_limit
//
// A request is captured at acceptance and executed once the result register is
// free or being drained, when its result is loaded into the output register; a
// new request is taken in that same cycle, so one request per cycle flows while
// out_ready stays high. Every cell that moves does so in that execute cycle.
// Reset clears the count, the capacity register (to 256) and the handshake state.
// A result held by out_ready low stops execution and drops in_ready once busy.
module positional_insert_delete_buffer import pidb_pkg::*; #(
	parameter int DEPTH      = PIDB_DEPTH,
	parameter int WORD_WIDTH = PIDB_WORD_WIDTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wr_en,
	input  logic [CAP_W-1:0]    cfg_wr_data,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [CMD_W-1:0]    command,
	input  logic [POS_W-1:0]    position,
	input  logic [VALUE_W-1:0]  value,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [STATUS_W-1:0] status,
	output logic [VALUE_W-1:0]  read_data,
	output logic [COUNT_W-1:0]  element_count
);

	localparam int IDX_W   = $clog2(DEPTH);
	// The count never exceeds the smaller of the depth and the 9-bit limit.
	localparam int CNT_W   = ($clog2(DEPTH + 1) < COUNT_W) ? $clog2(DEPTH + 1) : COUNT_W;
	// Compare width wide enough for position, count, limit and depth.
	localparam int CMP_W   = (($clog2(DEPTH + 1) > POS_W) ? $clog2(DEPTH + 1) : POS_W) + 1;
	localparam int VEXT_W  = (WORD_WIDTH > VALUE_W) ? WORD_WIDTH : VALUE_W;

	// Captured request.
	logic                 busy_q;
	cmd_t                 cmd_q;
	logic [POS_W-1:0]     pos_q;
	logic [VALUE_W-1:0]   val_q;

	logic [CAP_W-1:0]     cap_q;
	logic [CNT_W-1:0]     count_q;

	// Result register.
	logic                 out_valid_q;
	status_t              status_q;
	logic [VALUE_W-1:0]   rdata_q;

	logic                 in_fire;
	logic                 exec;
	status_t              st_c;
	pidb_op_t             op_c;
	logic [CMP_W-1:0]     pos_c;
	logic [CMP_W-1:0]     cnt_c;
	logic [CMP_W-1:0]     cap_c;
	logic                 full_c;
	logic [IDX_W-1:0]     cell_pos;
	logic [VEXT_W-1:0]    val_ext;
	logic [WORD_WIDTH-1:0] val_word;
	logic [WORD_WIDTH-1:0] rd_word;
	logic [VEXT_W-1:0]    rd_ext;

	// The request executes once the result register is free or being drained.
	assign exec     = busy_q && (!out_valid_q || out_ready);
	assign in_ready = !busy_q || exec;
	assign in_fire  = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_wr_en) begin
			cap_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (in_fire) begin
			busy_q <= 1'b1;
		end else if (exec) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			cmd_q <= cmd_t'(command);
			pos_q <= position;
			val_q <= value;
		end
	end

	// Status decision. A limit above the depth acts as the depth, and the
	// full check is made before the position check on an insert.
	assign pos_c  = CMP_W'(pos_q);
	assign cnt_c  = CMP_W'(count_q);
	assign cap_c  = CMP_W'(cap_q);
	assign full_c = (cnt_c >= cap_c) || (cnt_c >= CMP_W'(DEPTH));

	always_comb begin
		unique case (cmd_q)
			CMD_INSERT: begin
				if (full_c) begin
					st_c = ST_FULL;
				end else if (pos_c > cnt_c) begin
					st_c = ST_RANGE;
				end else begin
					st_c = ST_OK;
				end
			end
			CMD_REMOVE, CMD_READ, CMD_WRITE: begin
				st_c = (pos_c >= cnt_c) ? ST_RANGE : ST_OK;
			end
			default: begin
				st_c = ST_RANGE;
			end
		endcase
	end

	// Cells only move on a successful command that is executing now.
	always_comb begin
		op_c     = '0;
		if (exec && (st_c == ST_OK)) begin
			op_c.ins = (cmd_q == CMD_INSERT);
			op_c.rem = (cmd_q == CMD_REMOVE);
			op_c.wr  = (cmd_q == CMD_WRITE);
		end
	end

	// A successful position is always below the depth, so dropping high
	// bits here is safe.
	assign cell_pos = pos_c[IDX_W-1:0];
	assign val_ext  = VEXT_W'(val_q);
	assign val_word = val_ext[WORD_WIDTH-1:0];

	pidb_chain #(
		.DEPTH      (DEPTH),
		.WORD_WIDTH (WORD_WIDTH),
		.IDX_W      (IDX_W)
	) u_chain (
		.clk     (clk),
		.op      (op_c),
		.pos     (cell_pos),
		.val     (val_word),
		.rd_word (rd_word)
	);

	assign rd_ext = VEXT_W'(rd_word);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else if (exec) begin
			out_valid_q <= 1'b1;
			if (op_c.ins) begin
				count_q <= count_q + 1'b1;
			end else if (op_c.rem) begin
				count_q <= count_q - 1'b1;
			end
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (exec) begin
			status_q <= st_c;
			if ((cmd_q == CMD_READ) && (st_c == ST_OK)) begin
				rdata_q <= rd_ext[VALUE_W-1:0];
			end else begin
				rdata_q <= '0;
			end
		end
	end

	// The count output follows the register, which already reflects the
	// delivered command while its result waits.
	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign read_data     = rdata_q;
	assign element_count = COUNT_W'(count_q);

endmodule

// ===== src/pidb_check.sv =====
module pidb_check import pidb_pkg::*; (
	input logic                clk,
	input logic                arst_n,
	input logic                in_ready,
	input logic                out_valid,
	input logic                out_ready,
	input logic [STATUS_W-1:0] status,
	input logic [VALUE_W-1:0]  read_data,
	input logic [COUNT_W-1:0]  element_count
);

	// A held result keeps its whole payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) &&
		$stable(read_data) && $stable(element_count))
		else $error("result changed while stalled");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status == ST_OK) || (status == ST_FULL) || (status == ST_RANGE))
		else $error("undefined status code");

	a_fail_no_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != ST_OK) |-> (read_data == '0))
		else $error("failed request returned data");

	// Requests are refused only while a result is stuck at the output.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("in_ready low without output back-pressure");

endmodule

bind positional_insert_delete_buffer pidb_check u_pidb_check (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_ready      (in_ready),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.status        (status),
	.read_data     (read_data),
	.element_count (element_count)
);
